FILE: sv/sts_pkg.sv
// sts_pkg: shared widths, operation codes, result, read request and search state types
// for the sorted table search block. No dependencies.

package sts_pkg;

   localparam int CFG_WIDTH   = 9;
   localparam int INDEX_WIDTH = 8;
   localparam int KEY_WIDTH   = 32;
   localparam int POS_WIDTH   = 8;
   localparam int BOUND_WIDTH = CFG_WIDTH + 1;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic signed [BOUND_WIDTH-1:0] BOUND_ONE = BOUND_WIDTH'(1);

   typedef struct packed {
      logic                 found;
      logic [POS_WIDTH-1:0] position;
   } result_type;

   typedef struct packed {
      logic                 enable;
      logic [CFG_WIDTH-1:0] index;
   } probe_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PROBE = 3'b010,
      ST_WAIT  = 3'b100
   } search_state_type;

endpackage

FILE: sv/sorted_table_binary_search_top.sv
// sorted_table_binary_search_top: sorted table with binary search lookup.
// Depends on sts_pkg, sts_table_mem and sts_search_engine.
//
//   channel   ports                                   direction
//   req       req_valid/req_stall, operation/index/value   in
//   rsp       rsp_valid/rsp_stall, found/position          out
//   csr       csr_write_enable, csr_write_data (count)     in
//
// a write transfer stores its entry at the edge it is taken
// a search makes at most floor(log2(count)) + 1 probes,
// one registered table read per probe
// a search ends in the rsp register; a stalled rsp holds it, and the next
// search runs its probes and then waits in place, holding off writes too
// reset (synchronous) empties the rsp register and the count; table
// contents are undefined until written

module sorted_table_binary_search_top
   import sts_pkg::*;
#(
   parameter int DEPTH       = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [INDEX_WIDTH-1:0]      req_index,
   input  logic signed [KEY_WIDTH-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [POS_WIDTH-1:0]        rsp_position,
   input  logic                        csr_write_enable,
   input  logic [CFG_WIDTH-1:0]        csr_write_data
);

   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CFG_WIDTH-1:0]          entry_count_ff, entry_count_in;
   logic [CFG_WIDTH-1:0]          count_clamp;
   logic                          req_transfer, idle, start, wr_en;
   logic [ADDR_WIDTH-1:0]         wr_addr, rd_addr;
   logic signed [VALUE_WIDTH-1:0] value_cut, rd_data;
   probe_type                     probe;

   assign entry_count_in = csr_write_enable ? csr_write_data : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   assign count_clamp = (32'(entry_count_ff) > DEPTH) ? CFG_WIDTH'(DEPTH) : entry_count_ff;

   assign req_stall    = !idle;
   assign req_transfer = req_valid && !req_stall;
   assign start        = req_transfer && (req_operation == OP_SEARCH);
   assign wr_en        = req_transfer && (req_operation == OP_WRITE)
                         && (32'(req_index) < DEPTH);
   assign wr_addr      = ADDR_WIDTH'(req_index);
   assign value_cut    = VALUE_WIDTH'(req_value);
   assign rd_addr      = ADDR_WIDTH'(probe.index);

   sts_table_mem #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .ADDR_WIDTH  (ADDR_WIDTH)
   ) u_table_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_cut),
      .rd_en   (probe.enable),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sts_search_engine #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_search_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .key          (value_cut),
      .count        (count_clamp),
      .probe        (probe),
      .rd_data      (rd_data),
      .idle         (idle),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position)
   );

endmodule

FILE: sv/sts_table_mem.sv
// sts_table_mem: table storage, one write port and one registered read port.
// Depends on nothing outside this file.

module sts_table_mem #(
   parameter int DEPTH       = 256,
   parameter int VALUE_WIDTH = 32,
   parameter int ADDR_WIDTH  = 8
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_WIDTH-1:0]         wr_addr,
   input  logic signed [VALUE_WIDTH-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_WIDTH-1:0]         rd_addr,
   output logic signed [VALUE_WIDTH-1:0] rd_data
);

   logic signed [VALUE_WIDTH-1:0] mem_ff [DEPTH];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sts_search_engine.sv
// sts_search_engine: binary search sequencer, one table probe per cycle,
// with the result output register. Depends on sts_pkg.

module sts_search_engine
   import sts_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [VALUE_WIDTH-1:0] key,
   input  logic [CFG_WIDTH-1:0]          count,
   output probe_type                     probe,
   input  logic signed [VALUE_WIDTH-1:0] rd_data,
   output logic                          idle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [POS_WIDTH-1:0]          rsp_position
);

   search_state_type state_ff, state_in;
   logic signed [BOUND_WIDTH-1:0] low_ff, low_in, high_ff, high_in;
   logic [CFG_WIDTH-1:0]          mid_ff, mid_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   result_type                    res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   result_type                    out_ff, out_in;

   logic signed [BOUND_WIDTH-1:0] cnt_b, init_high, mid_b, lo_up, hi_dn;
   logic signed [BOUND_WIDTH-1:0] span_up, span_dn, mid_up, mid_dn;
   logic [CFG_WIDTH-1:0]          init_mid;
   logic                          go_up, go_dn, hit, less, out_free;
   logic                          finish, load;
   result_type                    fin_res, load_res;

   assign cnt_b     = signed'({1'b0, count});
   assign init_high = cnt_b - BOUND_ONE;
   assign init_mid  = CFG_WIDTH'(init_high >>> 1);

   // both possible next probes, picked by the compare
   assign mid_b   = signed'({1'b0, mid_ff});
   assign lo_up   = mid_b + BOUND_ONE;
   assign hi_dn   = mid_b - BOUND_ONE;
   assign span_up = high_ff - lo_up;
   assign span_dn = hi_dn - low_ff;
   assign mid_up  = lo_up + (span_up >>> 1);
   assign mid_dn  = low_ff + (span_dn >>> 1);
   assign go_up   = (lo_up <= high_ff);
   assign go_dn   = (low_ff <= hi_dn);

   assign hit      = (rd_data == key_ff);
   assign less     = (rd_data < key_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      mid_in   = mid_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      probe    = '0;
      finish   = 1'b0;
      fin_res  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in  = key;
               low_in  = '0;
               high_in = init_high;
               mid_in  = init_mid;
               if (count == '0) begin
                  finish = 1'b1;
               end else begin
                  probe.enable = 1'b1;
                  probe.index  = init_mid;
                  state_in     = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (hit) begin
               finish           = 1'b1;
               fin_res.found    = 1'b1;
               fin_res.position = POS_WIDTH'(mid_ff);
            end else if (less) begin
               if (go_up) begin
                  low_in       = lo_up;
                  mid_in       = CFG_WIDTH'(mid_up);
                  probe.enable = 1'b1;
                  probe.index  = CFG_WIDTH'(mid_up);
               end else begin
                  finish = 1'b1;
               end
            end else begin
               if (go_dn) begin
                  high_in      = hi_dn;
                  mid_in       = CFG_WIDTH'(mid_dn);
                  probe.enable = 1'b1;
                  probe.index  = CFG_WIDTH'(mid_dn);
               end else begin
                  finish = 1'b1;
               end
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         res_in   = fin_res;
         state_in = out_free ? ST_IDLE : ST_WAIT;
      end
   end

   // output register, loaded straight from the last probe when free, else from the held result once free
   assign load     = out_free && (finish || (state_ff == ST_WAIT));
   assign load_res = finish ? fin_res : res_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_in       = out_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         out_in       = load_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
      mid_ff  <= mid_in;
      key_ff  <= key_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign idle         = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = out_ff.found;
   assign rsp_position = out_ff.position;

endmodule

FILE: sv/sts_checker.sv
// sts_checker: port level checks for the sorted table search block, bound
// to sorted_table_binary_search_top. Depends on sts_pkg.

module sts_checker
   import sts_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_operation,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_found,
   input logic [POS_WIDTH-1:0]        rsp_position,
   input logic                        csr_write_enable,
   input logic [CFG_WIDTH-1:0]        csr_write_data
);

   logic [CFG_WIDTH-1:0] cfg_ff, cfg_in;

   assign cfg_in = csr_write_enable ? csr_write_data : cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // reset leaves an empty output and an open input
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position))
      else $error("stalled result changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss with nonzero position");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> CFG_WIDTH'(rsp_position) < cfg_ff)
      else $error("hit position beyond entry count");

   // a write transfer never holds off the next transfer
   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == OP_WRITE) |=> !req_stall)
      else $error("stall after write transfer");

endmodule

bind sorted_table_binary_search_top sts_checker u_sts_checker (.*);

FILE: verif/testbench.sv
// testbench for sorted_table_binary_search_top: drives table writes and key searches,
// mirrors the table and count in a scoreboard class and checks every search result.
// Depends on sts_pkg and the block's rtl.

module testbench
   import sts_pkg::*;
();

   localparam int TABLE_DEPTH = 256;
   localparam int ITEM_TARGET = 1750;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 3000;
   localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = 32'sh7fff_ffff;

   class table_mirror;
      logic signed [KEY_WIDTH-1:0] entries [TABLE_DEPTH];
      logic [CFG_WIDTH-1:0]        entry_count;
      result_type                  pending_lookups[$];
      int                          errors;

      function new();
         foreach (entries[i]) entries[i] = '0;
         entry_count = '0;
         errors = 0;
      endfunction

      function result_type lookup_key(logic signed [KEY_WIDTH-1:0] key);
         int span;
         int lo;
         int hi;
         int mid;
         result_type hit;
         hit = '0;
         span = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
         lo = 0;
         hi = span - 1;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (entries[mid] == key) begin
               hit.found = 1'b1;
               hit.position = mid[POS_WIDTH-1:0];
               break;
            end else if (entries[mid] < key) begin
               lo = mid + 1;
            end else begin
               hi = mid - 1;
            end
         end
         return hit;
      endfunction

      function void take_request(logic op, logic [INDEX_WIDTH-1:0] index,
                                 logic signed [KEY_WIDTH-1:0] value);
         if (op == OP_WRITE) begin
            entries[index] = value;
         end else begin
            pending_lookups.push_back(lookup_key(value));
         end
      endfunction

      function void check_response(logic found, logic [POS_WIDTH-1:0] position);
         result_type want;
         if (pending_lookups.size() == 0) begin
            $display("%0t: result with nothing expected, found %b position %0d",
                     $time, found, position);
            errors++;
            return;
         end
         want = pending_lookups.pop_front();
         if (found !== want.found) begin
            $display("%0t: found expected %b actual %b", $time, want.found, found);
            errors++;
         end
         if (position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position, position);
            errors++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_operation = OP_WRITE;
   logic [INDEX_WIDTH-1:0]      req_index = '0;
   logic signed [KEY_WIDTH-1:0] req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_found;
   logic [POS_WIDTH-1:0]        rsp_position;
   logic                        csr_write_enable = 1'b0;
   logic [CFG_WIDTH-1:0]        csr_write_data = '0;

   table_mirror mirror;
   int          sent_items = 0;
   int          send_gap_max = 15;
   int          rsp_gap_max = 15;
   bit          hold_output = 1'b0;

   always #4 clock = ~clock;

   sorted_table_binary_search_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_index        (req_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   task automatic offer_item(logic op, logic [INDEX_WIDTH-1:0] index,
                             logic signed [KEY_WIDTH-1:0] value);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_index <= index;
      req_value <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      mirror.take_request(op, index, value);
      sent_items++;
   endtask

   task automatic set_entry_count(logic [CFG_WIDTH-1:0] new_count);
      req_valid <= 1'b0;
      while (mirror.pending_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= new_count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mirror.entry_count = new_count;
   endtask

   // ascending entries 0..span-1, duplicates allowed, clamped at the top
   task automatic fill_sorted(int span);
      longint level;
      longint step_max;
      level = ($urandom_range(0, 3) == 0) ? longint'(KEY_MIN) : longint'(int'($urandom));
      case ($urandom_range(0, 2))
         0: step_max = 2;
         1: step_max = 1000;
         default: step_max = 64'd4294967295 / (span + 1);
      endcase
      for (int i = 0; i < span; i++) begin
         offer_item(OP_WRITE, i[INDEX_WIDTH-1:0], level[KEY_WIDTH-1:0]);
         level += longint'($urandom_range(0, 32'(step_max)));
         if (level > KEY_MAX) level = KEY_MAX;
      end
   endtask

   function automatic logic signed [KEY_WIDTH-1:0] pick_key(int span);
      int roll;
      logic signed [KEY_WIDTH-1:0] entry;
      roll = $urandom_range(0, 99);
      entry = (span > 0) ? mirror.entries[$urandom_range(0, span - 1)] : '0;
      if (span > 0 && roll < 55) return entry;
      if (span > 0 && roll < 70) return roll[0] ? entry + 1 : entry - 1;
      if (roll < 80) return roll[0] ? KEY_MAX : KEY_MIN;
      return $urandom;
   endfunction

   // result side: random stall before each transfer, one long hold on request
   initial begin
      int wait_cycles;
      wait (reset == 1'b0);
      forever begin
         if (hold_output) begin
            hold_output = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         wait_cycles = $urandom_range(0, rsp_gap_max);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         mirror.check_response(rsp_found, rsp_position);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int phase;
      int span;
      logic [CFG_WIDTH-1:0] new_count;
      mirror = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero count: nothing probed
      offer_item(OP_SEARCH, 8'hff, '0);
      offer_item(OP_SEARCH, 8'h00, KEY_MIN);
      offer_item(OP_SEARCH, 8'h5a, KEY_MAX);
      offer_item(OP_WRITE, 8'd0, KEY_MIN);
      offer_item(OP_WRITE, 8'd1, -32'sd5);
      offer_item(OP_WRITE, 8'd2, -32'sd5);
      offer_item(OP_WRITE, 8'd3, 32'sd0);
      offer_item(OP_WRITE, 8'd4, 32'sd1);
      offer_item(OP_WRITE, 8'd5, 32'sd100);
      offer_item(OP_WRITE, 8'd6, KEY_MAX - 1);
      offer_item(OP_WRITE, 8'd7, KEY_MAX);
      offer_item(OP_WRITE, 8'd255, 32'sh5555_5555);
      set_entry_count(9'd8);
      offer_item(OP_SEARCH, 8'd0, KEY_MIN);
      offer_item(OP_SEARCH, 8'd0, KEY_MAX);
      offer_item(OP_SEARCH, 8'd0, -32'sd5);
      offer_item(OP_SEARCH, 8'd0, 32'sd2);
      offer_item(OP_SEARCH, 8'd0, 32'sd100);
      offer_item(OP_SEARCH, 8'd0, KEY_MAX - 1);
      // unsorted table
      offer_item(OP_WRITE, 8'd3, KEY_MAX);
      offer_item(OP_SEARCH, 8'd0, 32'sd0);
      offer_item(OP_SEARCH, 8'd0, 32'sd1);
      set_entry_count(9'd1);
      offer_item(OP_SEARCH, 8'd0, KEY_MIN);
      offer_item(OP_SEARCH, 8'd0, -32'sd5);

      phase = 0;
      while (sent_items < ITEM_TARGET) begin
         phase++;
         case (phase)
            1: new_count = 9'd256;
            2: new_count = 9'd511;
            5: new_count = 9'd0;
            default: new_count = ($urandom_range(0, 7) == 0)
                                 ? CFG_WIDTH'($urandom_range(255, 511))
                                 : CFG_WIDTH'($urandom_range(1, 40));
         endcase
         span = (new_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(new_count);
         send_gap_max = (phase == 2 || $urandom_range(0, 2) == 0) ? 0 : 15;
         rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
         set_entry_count(new_count);
         fill_sorted(span);
         if (phase == 2) hold_output = 1'b1;
         repeat ((span > 64) ? 100 : 40) begin
            if ($urandom_range(0, 99) < 8) begin
               offer_item(OP_WRITE, INDEX_WIDTH'($urandom_range(0, 255)), $urandom);
            end else begin
               offer_item(OP_SEARCH, INDEX_WIDTH'($urandom_range(0, 255)), pick_key(span));
            end
         end
      end

      req_valid <= 1'b0;
      while (mirror.pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.pending_lookups.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, mirror.pending_lookups.size());
         mirror.errors++;
      end
      if (mirror.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/sts_pkg.sv
sv/sts_table_mem.sv
sv/sts_search_engine.sv
sv/sorted_table_binary_search_top.sv
sv/sts_checker.sv
verif/testbench.sv
